/* rtl/lokt_pkg.sv */
// Shared types and constants for the level-order key table.
// Holds the transfer payload structs, command/status codes and sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lokt_pkg;

    // Default table depth and fixed field widths
    localparam int DEF_CAPACITY = 64;
    localparam int KEY_W        = 32;
    localparam int FILL_W       = 7;

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    // Result status codes
    localparam logic [1:0] STS_DONE = 2'd0;
    localparam logic [1:0] STS_FULL = 2'd1;
    localparam logic [1:0] STS_MISS = 2'd2;

    typedef struct packed {
        logic [1:0]              cmd;
        logic signed [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic              found;
        logic [1:0]        status;
        logic [FILL_W-1:0] fill;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE,
        ST_RESP
    } t_state;

endpackage

`default_nettype wire

/* rtl/lokt_mem.sv */
// Key store: single write port, single registered read port.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module lokt_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int W     = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/lokt_seq.sv */
// Command sequencer: entry count, scan counter and the single key comparator.
// Depends on lokt_pkg; drives the ports of lokt_mem.
`timescale 1ns / 1ps
`default_nettype none

module lokt_seq #(
    parameter int CAPACITY = lokt_pkg::DEF_CAPACITY,
    parameter int AW       = 6,
    parameter int CW       = 7
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // command transfer
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire lokt_pkg::t_req              i_req,
    // result hand-off to the output register
    input  wire logic                        i_room,
    output logic                             o_done,
    output lokt_pkg::t_rsp                   o_rsp,
    // key store
    output logic                             o_we,
    output logic [AW-1:0]                    o_waddr,
    output logic [lokt_pkg::KEY_W-1:0]       o_wdata,
    output logic [AW-1:0]                    o_raddr,
    input  wire logic [lokt_pkg::KEY_W-1:0]  i_rdata
);

    import lokt_pkg::*;

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    t_state            r_state, n_state;
    logic              r_is_del, n_is_del;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]     r_cmp_idx, n_cmp_idx;
    logic              r_hit, n_hit;
    logic [AW-1:0]     r_hit_idx, n_hit_idx;
    t_rsp              r_rsp, n_rsp;
    logic [CW-1:0]     w_last;
    logic [CW-1:0]     w_inc;

    // Truncate or extend a count to the result field
    function automatic logic [FILL_W-1:0] fill_of(input logic [CW-1:0] c);
        logic [CW+FILL_W-1:0] ext;
        ext = {{FILL_W{1'b0}}, c};
        return ext[FILL_W-1:0];
    endfunction

    assign w_last = r_count - ONE_C;
    assign w_inc  = r_count + ONE_C;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
            r_hit     <= n_hit;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_is_del  <= n_is_del;
        r_key     <= n_key;
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_hit_idx <= n_hit_idx;
        r_rsp     <= n_rsp;
    end

    // Next state and outputs
    always_comb begin
        n_state   = r_state;
        n_is_del  = r_is_del;
        n_key     = r_key;
        n_count   = r_count;
        n_idx     = r_idx;
        n_cmp_vld = 1'b0;
        n_cmp_idx = r_cmp_idx;
        n_hit     = r_hit;
        n_hit_idx = r_hit_idx;
        n_rsp     = r_rsp;
        o_ready   = 1'b0;
        o_done    = 1'b0;
        o_we      = 1'b0;
        o_waddr   = r_count[AW-1:0];
        o_wdata   = r_key;
        o_raddr   = r_idx[AW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                o_ready     = 1'b1;
                o_wdata     = i_req.key;
                n_rsp.found = 1'b0;
                n_rsp.fill  = fill_of(r_count);
                if (i_valid) begin
                    unique case (i_req.cmd)
                        CMD_INSERT: begin
                            // append at the next free slot unless full
                            if (r_count == CAP_C) begin
                                n_rsp.status = STS_FULL;
                            end else begin
                                o_we         = 1'b1;
                                n_count      = w_inc;
                                n_rsp.status = STS_DONE;
                                n_rsp.fill   = fill_of(w_inc);
                            end
                            n_state = ST_RESP;
                        end
                        CMD_SEARCH, CMD_DELETE: begin
                            n_is_del = (i_req.cmd == CMD_DELETE);
                            n_key    = i_req.key;
                            n_idx    = '0;
                            n_hit    = 1'b0;
                            n_state  = ST_SCAN;
                        end
                        default: begin
                            // unused code: report done, change nothing
                            n_rsp.status = STS_DONE;
                            n_state      = ST_RESP;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // compare the entry read last cycle, keep the last match
                if (r_cmp_vld && (i_rdata == r_key)) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_cmp_idx;
                end
                if (r_idx != r_count) begin
                    // issue the next read
                    n_idx     = r_idx + ONE_C;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx[AW-1:0];
                end else begin
                    // scan over; fetch the last entry for a delete move
                    o_raddr    = w_last[AW-1:0];
                    n_rsp.fill = fill_of(r_count);
                    if (!n_hit) begin
                        n_rsp.found  = 1'b0;
                        n_rsp.status = STS_MISS;
                        n_state      = ST_RESP;
                    end else if (!r_is_del) begin
                        n_rsp.found  = 1'b1;
                        n_rsp.status = STS_DONE;
                        n_state      = ST_RESP;
                    end else begin
                        n_state = ST_MOVE;
                    end
                end
            end

            ST_MOVE: begin
                // overwrite the match with the last entry and shrink
                o_we         = 1'b1;
                o_waddr      = r_hit_idx;
                o_wdata      = i_rdata;
                n_count      = w_last;
                n_rsp.found  = 1'b1;
                n_rsp.status = STS_DONE;
                n_rsp.fill   = fill_of(w_last);
                n_state      = ST_RESP;
            end

            ST_RESP: begin
                // hand the result over once the output register has room
                if (i_room) begin
                    o_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_rsp = r_rsp;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count exceeds capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_req.cmd == CMD_INSERT) && (r_count != CAP_C))
        |=> (r_count == $past(r_count) + ONE_C))
        else $error("insert did not advance entry count");

    a_move_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOVE) |-> (r_hit && r_is_del && (r_count != '0)))
        else $error("delete move without a match");

    a_done_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (i_room && (r_state == ST_RESP)))
        else $error("result handed off without room");
`endif

endmodule

`default_nettype wire

/* rtl/level_order_key_table.sv */
// Top level of the level-order key table: key store, sequencer, result register.
// Depends on lokt_pkg, lokt_mem and lokt_seq.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a complete binary tree of signed 32-bit keys as a level-order table
// of CAPACITY entries plus a count. One command is worked at a time, and
// o_in_ready is high only while the sequencer is idle. Insert and the unused
// command code go from idle straight to the result state. Search and
// delete read every stored entry once through the single read port of the
// key store into one 32-bit comparator; a delete that hits then passes
// through a move state that copies the last entry into the matched slot.
// The result register lets a finished result wait for the consumer while
// the next command is taken. The key store is never cleared: only entries
// below the count are used, so no clearing pass follows reset.
module level_order_key_table #(
    parameter int CAPACITY = lokt_pkg::DEF_CAPACITY
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire lokt_pkg::t_req i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output lokt_pkg::t_rsp      o_out
);

    import lokt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [KEY_W-1:0] w_wdata;
    logic [AW-1:0]    w_raddr;
    logic [KEY_W-1:0] w_rdata;
    logic             w_done;
    logic             w_room;
    t_rsp             w_rsp;
    logic             r_out_vld;
    t_rsp             r_out;

    lokt_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .W     (KEY_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    lokt_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_req   (i_in),
        .i_room  (w_room),
        .o_done  (w_done),
        .o_rsp   (w_rsp),
        .o_we    (w_we),
        .o_waddr (w_waddr),
        .o_wdata (w_wdata),
        .o_raddr (w_raddr),
        .i_rdata (w_rdata)
    );

    // Output register has room when empty or being drained this cycle
    assign w_room = !r_out_vld || i_out_ready;

    // Hold the result until its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_done) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_rsp;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

`default_nettype wire

/* tb/lokt_checker.sv */
// Scoreboard for the level-order key table: predicts each result from accepted commands
// and compares it field by field with what the block returns.
// Depends on lokt_pkg.
`timescale 1ns / 1ps

module lokt_checker (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_ready,
    input  wire lokt_pkg::t_req i_in,
    input  wire logic           i_out_valid,
    input  wire logic           i_out_ready,
    input  wire lokt_pkg::t_rsp i_out,
    output int                  o_errors,
    output int                  o_pending
);

    import lokt_pkg::*;

    // Shadow copy of the level-order table
    logic [KEY_W-1:0] table_keys [DEF_CAPACITY];
    int               table_fill;
    t_rsp             expected_rsp_q [$];
    int               mismatch_count;

    // Apply one command to the shadow table and return the result it must produce
    function automatic t_rsp apply_command(input t_req req);
        t_rsp rsp;
        int   hit;
        rsp.found  = 1'b0;
        rsp.status = STS_DONE;
        hit        = -1;
        case (req.cmd)
            CMD_INSERT: begin
                if (table_fill >= DEF_CAPACITY) begin
                    rsp.status = STS_FULL;
                end else begin
                    table_keys[table_fill] = req.key;
                    table_fill++;
                end
            end
            CMD_SEARCH, CMD_DELETE: begin
                // Keep the last match in level order
                for (int i = 0; i < table_fill; i++) begin
                    if (table_keys[i] == req.key) hit = i;
                end
                if (hit < 0) begin
                    rsp.status = STS_MISS;
                end else begin
                    rsp.found = 1'b1;
                    // Move the deepest, rightmost node into the hole and shrink
                    if (req.cmd == CMD_DELETE) begin
                        table_keys[hit] = table_keys[table_fill-1];
                        table_fill--;
                    end
                end
            end
            default: ;
        endcase
        rsp.fill = table_fill[FILL_W-1:0];
        return rsp;
    endfunction

    // Watch both channels; check the output transfer before queuing the new command
    always @(posedge i_clk) begin : watch_channels
        t_rsp want;
        if (!i_rst_n) begin
            table_fill     = 0;
            mismatch_count = 0;
            expected_rsp_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_rsp_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] unexpected result: found=%0d status=%0d fill=%0d",
                                 $realtime, i_out.found, i_out.status, i_out.fill);
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (i_out.found !== want.found || i_out.status !== want.status ||
                        i_out.fill !== want.fill) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $write("[%0t] result mismatch: expected found=%0d status=%0d ",
                                   $realtime, want.found, want.status);
                            $display("fill=%0d, got found=%0d status=%0d fill=%0d",
                                     want.fill, i_out.found, i_out.status, i_out.fill);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_rsp_q.push_back(apply_command(i_in));
        end
        o_pending <= expected_rsp_q.size();
        o_errors  <= mismatch_count;
    end

endmodule

/* tb/tb_level_order_key_table.sv */
// Testbench top for the level-order key table: clock, reset, command stimulus,
// random stalls on both channels and the final verdict. Depends on lokt_pkg,
// level_order_key_table and lokt_checker.
`timescale 1ns / 1ps

module tb_level_order_key_table;
    import lokt_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         POOL_SIZE  = 12;
    localparam int         NUM_PHASES = 11;
    localparam int         PHASE_LEN  = 150;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    t_req in_req;
    logic out_valid;
    logic out_ready;
    t_rsp out_rsp;
    int   errors;
    int   pending;

    // Stimulus shaping, changed per phase
    bit               quiet;
    int               insert_pct;
    int               phase_insert_pct [NUM_PHASES] =
                          '{80, 15, 45, 90, 10, 60, 20, 85, 15, 50, 25};
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    // 100 MHz clock
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    level_order_key_table uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_rsp)
    );

    lokt_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in        (in_req),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out       (out_rsp),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Idle cycles before the next transfer on either side
    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 16);
    endfunction

    // Mostly keys from a small pool so that hits and duplicates are common
    function automatic logic [KEY_W-1:0] pick_key();
        int sel = $urandom_range(0, 19);
        case (sel)
            0, 1:    return $urandom();
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h0000_0000;
            5:       return 32'hFFFF_FFFF;
            default: return key_pool[$urandom_range(0, POOL_SIZE-1)];
        endcase
    endfunction

    // Weight the operations by the current phase's insert share
    function automatic logic [1:0] pick_cmd();
        int roll = $urandom_range(0, 99);
        if (roll < 3) return CMD_UNUSED;
        if (roll < 3 + insert_pct) return CMD_INSERT;
        if (roll[0]) return CMD_SEARCH;
        return CMD_DELETE;
    endfunction

    // Present one command and hold it until the transfer
    task automatic send_command(input logic [1:0] cmd, input logic [KEY_W-1:0] key);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= '{cmd: cmd, key: key};
        @(posedge clk);
        while (!(in_valid && in_ready)) @(posedge clk);
    endtask

    // Result side: stall a random number of cycles per result
    initial begin : drain_results
        int stall;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
        end
    end

    // Command side and verdict
    initial begin : drive_commands
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_req     <= '0;
        quiet      = 1'b0;
        insert_pct = 50;
        foreach (key_pool[i]) key_pool[i] = $urandom();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: misses and the unused code
        send_command(CMD_SEARCH, 32'd5);
        send_command(CMD_DELETE, 32'd5);
        send_command(CMD_UNUSED, 32'd5);
        // Key extremes, one duplicate
        send_command(CMD_INSERT, 32'h7FFF_FFFF);
        send_command(CMD_INSERT, 32'h8000_0000);
        send_command(CMD_INSERT, 32'h0000_0000);
        send_command(CMD_INSERT, 32'hFFFF_FFFF);
        send_command(CMD_INSERT, 32'h7FFF_FFFF);
        send_command(CMD_SEARCH, 32'h8000_0000);
        send_command(CMD_SEARCH, 32'h0000_0001);
        // Last match is the last entry: just drop it
        send_command(CMD_DELETE, 32'h7FFF_FFFF);
        send_command(CMD_SEARCH, 32'h7FFF_FFFF);
        // Match in the middle: last entry moves into the hole
        send_command(CMD_DELETE, 32'h8000_0000);
        send_command(CMD_UNUSED, 32'hFFFF_FFFF);
        send_command(CMD_SEARCH, 32'hFFFF_FFFF);
        send_command(CMD_SEARCH, 32'h8000_0000);
        send_command(CMD_DELETE, 32'h0000_0000);
        send_command(CMD_DELETE, 32'hFFFF_FFFF);
        send_command(CMD_DELETE, 32'h7FFF_FFFF);
        send_command(CMD_DELETE, 32'h0000_0001);
        send_command(CMD_SEARCH, 32'h7FFF_FFFF);

        // Random phases alternate between filling to capacity and draining
        for (int p = 0; p < NUM_PHASES; p++) begin
            insert_pct = phase_insert_pct[p];
            quiet      = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_LEN; i++)
                send_command(pick_cmd(), pick_key());
        end
        in_valid <= 1'b0;
        quiet    = 1'b0;

        // Let the checker count the last transfer, then drain and allow for stray results
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hang guard
    initial begin : watchdog
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
